// File: rtl/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared definitions for the preemptive priority scheduler
// Sizes, command codes, scheduler codes and the structs that travel between
// the controller and the chain of task cells.
// ----------------------------------------------------------------------------
package pps_pkg;

   // table and time sizes
   localparam int MAX_TASKS  = 16;
   localparam int TIME_BITS  = 16;
   localparam int FIELD_BITS = 16;
   localparam int PRIO_BITS  = 8;
   localparam int SLOT_BITS  = 4;
   localparam int IDX_BITS   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_BITS = $clog2(MAX_TASKS + 1);
   localparam int CODE_BITS  = $clog2(MAX_TASKS + 2);

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // served-slot codes beside the slot numbers themselves
   localparam logic [CODE_BITS-1:0] IDLE_CODE = CODE_BITS'(MAX_TASKS);
   localparam logic [CODE_BITS-1:0] NONE_CODE = {CODE_BITS{1'b1}};

   // best candidate so far, handed from cell to cell
   typedef struct packed {
      logic                  found;
      logic [IDX_BITS-1:0]   slot;
      logic [PRIO_BITS-1:0]  prio;
      logic [FIELD_BITS-1:0] arrival;
      logic [FIELD_BITS-1:0] burst;
      logic [FIELD_BITS-1:0] remaining;
   } token_type;

   // slot write broadcast to every cell
   typedef struct packed {
      logic                  en;
      logic [IDX_BITS-1:0]   slot;
      logic [FIELD_BITS-1:0] arrival;
      logic [FIELD_BITS-1:0] burst;
      logic [PRIO_BITS-1:0]  prio;
   } load_type;

   // service broadcast: one tick of work for the winning slot
   typedef struct packed {
      logic                en;
      logic [IDX_BITS-1:0] slot;
   } serve_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// File: rtl/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: top level of the task scheduler
// Loads task slots and, on each tick command, serves the most urgent
// arrived task and reports the tick on a one-cycle result strobe.
// ----------------------------------------------------------------------------
// A load beat (req_cmd = 0) gives no result and leaves busy low. A tick
// beat (req_cmd = 1) runs the SCAN, UPDATE and FINISH states: the
// best-candidate token walks the chain of task cells one cell per clock,
// then UPDATE applies the service and FINISH builds the result. The result
// beat is on the rsp_ ports for exactly one cycle, flagged by rsp_valid, and
// cannot be held off; a new command may be issued in that same cycle.
// Ticks after every task finishes report idle.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_burst_length,
   input  logic [7:0]  req_task_priority,
   output logic        rsp_valid,
   output logic        rsp_is_idle,
   output logic [3:0]  rsp_running_slot,
   output logic        rsp_switched,
   output logic [15:0] rsp_tick_start,
   output logic        rsp_finished,
   output logic [15:0] rsp_completion_time,
   output logic [15:0] rsp_turnaround,
   output logic [15:0] rsp_waiting,
   output logic        rsp_all_done
);

   pps_pkg::state_type             state_ff, state_in;
   logic [pps_pkg::IDX_BITS-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [pps_pkg::TIME_BITS-1:0]  now_time_ff, now_time_in;
   logic [pps_pkg::TIME_BITS-1:0]  start_ff;
   logic [pps_pkg::CODE_BITS-1:0]  last_served_ff;
   logic [pps_pkg::COUNT_BITS-1:0] loaded_count_ff, loaded_count_in;
   logic [pps_pkg::COUNT_BITS-1:0] done_count_ff, done_count_in;
   pps_pkg::token_type             win_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_is_idle_ff;
   logic [3:0]                     rsp_running_slot_ff;
   logic                           rsp_switched_ff;
   logic [15:0]                    rsp_tick_start_ff;
   logic                           rsp_finished_ff;
   logic [15:0]                    rsp_completion_time_ff;
   logic [15:0]                    rsp_turnaround_ff;
   logic [15:0]                    rsp_waiting_ff;
   logic                           rsp_all_done_ff;

   logic                           accept;
   logic                           slot_hit;
   logic [pps_pkg::IDX_BITS-1:0]   slot_idx;
   pps_pkg::load_type              load;
   pps_pkg::serve_type             serve;
   pps_pkg::token_type             tok_chain [pps_pkg::MAX_TASKS+1];
   logic [pps_pkg::MAX_TASKS-1:0]  valid_vec;
   logic [pps_pkg::MAX_TASKS-1:0]  done_vec;
   pps_pkg::token_type             tail;
   logic                           tail_fin;
   logic [pps_pkg::TIME_BITS-1:0]  next_time;
   logic [pps_pkg::CODE_BITS-1:0]  code;
   logic [31:0]                    tat;
   logic [31:0]                    wt;
   logic                           fin;

   assign busy     = (state_ff != pps_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign slot_hit = (32'(req_slot) < pps_pkg::MAX_TASKS);
   assign slot_idx = pps_pkg::IDX_BITS'(req_slot);

   // broadcast slot writes to the chain
   always_comb begin
      load.en      = accept && (req_cmd == pps_pkg::CMD_LOAD) && slot_hit;
      load.slot    = slot_idx;
      load.arrival = req_arrival_time;
      load.burst   = req_burst_length;
      load.prio    = req_task_priority;
   end

   // serve the winner once its token has left the last cell
   assign tail       = tok_chain[pps_pkg::MAX_TASKS];
   assign tail_fin   = tail.found && (tail.remaining == 1);
   assign serve.en   = (state_ff == pps_pkg::ST_UPDATE) && tail.found;
   assign serve.slot = tail.slot;

   // chain of task cells; the leftmost cell sees an empty token
   assign tok_chain[0] = '0;

   for (genvar g = 0; g < pps_pkg::MAX_TASKS; g++) begin : g_cell
      pps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (pps_pkg::IDX_BITS'(g)),
         .load       (load),
         .serve      (serve),
         .now_time   (now_time_ff),
         .tok_in     (tok_chain[g]),
         .tok_out    (tok_chain[g+1]),
         .valid_out  (valid_vec[g]),
         .done_out   (done_vec[g])
      );
   end

   // saturating time advance
   assign next_time = (now_time_ff == pps_pkg::TIME_MAX) ? now_time_ff
                                                         : now_time_ff + 1'b1;

   // sequence a tick: scan the chain, serve, report
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            scan_cnt_in = '0;
            if (accept && (req_cmd == pps_pkg::CMD_TICK)) begin
               state_in = pps_pkg::ST_SCAN;
            end
         end
         pps_pkg::ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == pps_pkg::IDX_BITS'(pps_pkg::MAX_TASKS - 1)) begin
               state_in = pps_pkg::ST_UPDATE;
            end
         end
         pps_pkg::ST_UPDATE: begin
            state_in = pps_pkg::ST_FINISH;
         end
         pps_pkg::ST_FINISH: begin
            state_in = pps_pkg::ST_IDLE;
         end
         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

   // track loaded and finished slot counts
   always_comb begin
      loaded_count_in = loaded_count_ff;
      done_count_in   = done_count_ff;
      if (load.en) begin
         if (!valid_vec[slot_idx]) begin
            loaded_count_in = loaded_count_ff + 1'b1;
         end else if (done_vec[slot_idx]) begin
            done_count_in = done_count_in - 1'b1;
         end
         if (req_burst_length == '0) begin
            done_count_in = done_count_in + 1'b1;
         end
      end else if ((state_ff == pps_pkg::ST_UPDATE) && tail_fin) begin
         done_count_in = done_count_ff + 1'b1;
      end
   end

   assign now_time_in = (state_ff == pps_pkg::ST_UPDATE) ? next_time : now_time_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pps_pkg::ST_IDLE;
         scan_cnt_ff     <= '0;
         now_time_ff     <= '0;
         last_served_ff  <= pps_pkg::NONE_CODE;
         loaded_count_ff <= '0;
         done_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         scan_cnt_ff     <= scan_cnt_in;
         now_time_ff     <= now_time_in;
         loaded_count_ff <= loaded_count_in;
         done_count_ff   <= done_count_in;
         rsp_valid_ff    <= (state_ff == pps_pkg::ST_FINISH);
         if (state_ff == pps_pkg::ST_FINISH) begin
            last_served_ff <= code;
         end
      end
   end

   // hold the winner and the tick start for the report cycle
   always_ff @(posedge clock) begin
      if (state_ff == pps_pkg::ST_UPDATE) begin
         win_ff   <= tail;
         start_ff <= now_time_ff;
      end
   end

   // build the result beat from the held winner
   always_comb begin
      code = win_ff.found ? pps_pkg::CODE_BITS'(win_ff.slot) : pps_pkg::IDLE_CODE;
      fin  = win_ff.found && (win_ff.remaining == 1);
      tat  = 32'(now_time_ff) - 32'(win_ff.arrival);
      wt   = (tat >= 32'(win_ff.burst)) ? (tat - 32'(win_ff.burst)) : '0;
   end

   // result payload registers
   always_ff @(posedge clock) begin
      if (state_ff == pps_pkg::ST_FINISH) begin
         rsp_is_idle_ff         <= !win_ff.found;
         rsp_running_slot_ff    <= win_ff.found ? 4'(win_ff.slot) : 4'd0;
         rsp_switched_ff        <= (code != last_served_ff);
         rsp_tick_start_ff      <= 16'(start_ff);
         rsp_finished_ff        <= fin;
         rsp_completion_time_ff <= fin ? 16'(now_time_ff) : 16'd0;
         rsp_turnaround_ff      <= fin ? tat[15:0] : 16'd0;
         rsp_waiting_ff         <= fin ? wt[15:0] : 16'd0;
         rsp_all_done_ff        <= (done_count_ff == loaded_count_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_idle         = rsp_is_idle_ff;
   assign rsp_running_slot    = rsp_running_slot_ff;
   assign rsp_switched        = rsp_switched_ff;
   assign rsp_tick_start      = rsp_tick_start_ff;
   assign rsp_finished        = rsp_finished_ff;
   assign rsp_completion_time = rsp_completion_time_ff;
   assign rsp_turnaround      = rsp_turnaround_ff;
   assign rsp_waiting         = rsp_waiting_ff;
   assign rsp_all_done        = rsp_all_done_ff;

   // a result beat only follows the report cycle
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == pps_pkg::ST_FINISH))
      else $error("result beat without a report cycle");

   // finished slots never outnumber loaded slots
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      done_count_ff <= loaded_count_ff)
      else $error("done count exceeds loaded count");

   // a tick beat makes the block busy on the next cycle
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == pps_pkg::CMD_TICK)) |=> busy)
      else $error("tick accepted without going busy");

   // a completion is never reported on an idle tick
   a_fin_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |-> !rsp_is_idle)
      else $error("completion reported on an idle tick");

   // time only moves in the service cycle
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pps_pkg::ST_UPDATE) |=> $stable(now_time_ff))
      else $error("time moved outside the service cycle");

endmodule

// File: rtl/pps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cell: one task slot of the scheduler chain
// Holds the slot's arrival, burst, remaining time and priority, merges
// itself into the best-candidate token from its left neighbor and registers
// the token for its right neighbor every cycle.
// ----------------------------------------------------------------------------
module pps_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pps_pkg::IDX_BITS-1:0]  cell_index,
   input  pps_pkg::load_type             load,
   input  pps_pkg::serve_type            serve,
   input  logic [pps_pkg::TIME_BITS-1:0] now_time,
   input  pps_pkg::token_type            tok_in,
   output pps_pkg::token_type            tok_out,
   output logic                          valid_out,
   output logic                          done_out
);

   logic                           valid_ff;
   logic                           done_ff;
   logic [pps_pkg::FIELD_BITS-1:0] arrival_ff;
   logic [pps_pkg::FIELD_BITS-1:0] burst_ff;
   logic [pps_pkg::FIELD_BITS-1:0] remaining_ff;
   logic [pps_pkg::PRIO_BITS-1:0]  prio_ff;
   pps_pkg::token_type             tok_ff;
   pps_pkg::token_type             tok_in_mux;
   logic                           eligible;
   logic                           take;

   // decide whether this slot beats the incoming candidate
   always_comb begin
      eligible = valid_ff && !done_ff && (remaining_ff != '0) &&
                 (32'(arrival_ff) <= 32'(now_time));
      take     = eligible && (!tok_in.found || (prio_ff < tok_in.prio));
      tok_in_mux = tok_in;
      if (take) begin
         tok_in_mux.found     = 1'b1;
         tok_in_mux.slot      = cell_index;
         tok_in_mux.prio      = prio_ff;
         tok_in_mux.arrival   = arrival_ff;
         tok_in_mux.burst     = burst_ff;
         tok_in_mux.remaining = remaining_ff;
      end
   end

   // hand the token to the right neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.found <= 1'b0;
      end else begin
         tok_ff.found <= tok_in_mux.found;
      end
      tok_ff.slot      <= tok_in_mux.slot;
      tok_ff.prio      <= tok_in_mux.prio;
      tok_ff.arrival   <= tok_in_mux.arrival;
      tok_ff.burst     <= tok_in_mux.burst;
      tok_ff.remaining <= tok_in_mux.remaining;
   end

   // slot status: write on load, retire when the last tick is served
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else if (load.en && (load.slot == cell_index)) begin
         valid_ff <= 1'b1;
         done_ff  <= (load.burst == '0);
      end else if (serve.en && (serve.slot == cell_index) && (remaining_ff == 1)) begin
         done_ff  <= 1'b1;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (load.en && (load.slot == cell_index)) begin
         arrival_ff   <= load.arrival;
         burst_ff     <= load.burst;
         remaining_ff <= load.burst;
         prio_ff      <= load.prio;
      end else if (serve.en && (serve.slot == cell_index) && (remaining_ff != '0)) begin
         remaining_ff <= remaining_ff - 1'b1;
      end
   end

   assign tok_out   = tok_ff;
   assign valid_out = valid_ff;
   assign done_out  = done_ff;

endmodule

// File: tb/sv/tb_preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler: self-checking bench for the scheduler
// Feeds load and tick beats through the start/busy handshake, predicts every
// tick report with a cycle-free model of the task table, and compares each
// rsp_valid beat field by field. Covers directed corner cases, random
// well-formed task sets with noise, and a closing run with no idling.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;

   localparam int LATENCY    = pps_pkg::MAX_TASKS + 3;
   localparam int RAND_BEATS = 560;

   typedef struct packed {
      logic                           cmd;
      logic [pps_pkg::SLOT_BITS-1:0]  slot;
      logic [pps_pkg::FIELD_BITS-1:0] arrival;
      logic [pps_pkg::FIELD_BITS-1:0] burst;
      logic [pps_pkg::PRIO_BITS-1:0]  prio;
   } task_beat_type;

   typedef struct packed {
      logic                           is_idle;
      logic [pps_pkg::SLOT_BITS-1:0]  running_slot;
      logic                           switched;
      logic [pps_pkg::FIELD_BITS-1:0] tick_start;
      logic                           finished;
      logic [pps_pkg::FIELD_BITS-1:0] completion_time;
      logic [pps_pkg::FIELD_BITS-1:0] turnaround;
      logic [pps_pkg::FIELD_BITS-1:0] waiting;
      logic                           all_done;
   } tick_report_type;

   // DUT pins; the inputs are known from time zero
   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic        req_cmd           = pps_pkg::CMD_LOAD;
   logic [3:0]  req_slot          = '0;
   logic [15:0] req_arrival_time  = '0;
   logic [15:0] req_burst_length  = '0;
   logic [7:0]  req_task_priority = '0;
   logic        busy;
   logic        rsp_valid;
   logic        rsp_is_idle;
   logic [3:0]  rsp_running_slot;
   logic        rsp_switched;
   logic [15:0] rsp_tick_start;
   logic        rsp_finished;
   logic [15:0] rsp_completion_time;
   logic [15:0] rsp_turnaround;
   logic [15:0] rsp_waiting;
   logic        rsp_all_done;

   // stimulus and scoreboard
   task_beat_type   pending_beats[$];
   tick_report_type expected_reports[$];
   task_beat_type   cur_beat;
   int              errors       = 0;
   int              quiet_beats  = 0;
   int              gap_left     = 0;
   int              idle_pct     = 12;
   int              beats_sent   = 0;
   int unsigned     queued_ticks = 0;

   // predicted task table
   logic [pps_pkg::FIELD_BITS-1:0] arr_tab   [pps_pkg::MAX_TASKS] = '{default: '0};
   logic [pps_pkg::FIELD_BITS-1:0] burst_tab [pps_pkg::MAX_TASKS] = '{default: '0};
   logic [pps_pkg::FIELD_BITS-1:0] rem_tab   [pps_pkg::MAX_TASKS] = '{default: '0};
   logic [pps_pkg::PRIO_BITS-1:0]  prio_tab  [pps_pkg::MAX_TASKS] = '{default: '0};
   bit                             valid_tab [pps_pkg::MAX_TASKS] = '{default: 1'b0};
   bit                             done_tab  [pps_pkg::MAX_TASKS] = '{default: 1'b0};
   logic [pps_pkg::TIME_BITS-1:0]  now_t     = '0;
   logic [pps_pkg::CODE_BITS-1:0]  last_code = pps_pkg::NONE_CODE;
   int                             loaded_n  = 0;
   int                             done_n    = 0;

   preemptive_priority_scheduler dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_slot            (req_slot),
      .req_arrival_time    (req_arrival_time),
      .req_burst_length    (req_burst_length),
      .req_task_priority   (req_task_priority),
      .rsp_valid           (rsp_valid),
      .rsp_is_idle         (rsp_is_idle),
      .rsp_running_slot    (rsp_running_slot),
      .rsp_switched        (rsp_switched),
      .rsp_tick_start      (rsp_tick_start),
      .rsp_finished        (rsp_finished),
      .rsp_completion_time (rsp_completion_time),
      .rsp_turnaround      (rsp_turnaround),
      .rsp_waiting         (rsp_waiting),
      .rsp_all_done        (rsp_all_done)
   );

   always #5 clock = ~clock;

   // Apply one accepted beat to the task table; queue a report for a tick.
   function automatic void schedule_beat(input task_beat_type b);
      int                             s;
      int                             best;
      bit                             found;
      logic [pps_pkg::PRIO_BITS-1:0]  best_pr;
      logic [pps_pkg::TIME_BITS-1:0]  nxt;
      logic [pps_pkg::CODE_BITS-1:0]  code;
      logic [pps_pkg::FIELD_BITS-1:0] tat;
      tick_report_type                r;
      if (b.cmd == pps_pkg::CMD_LOAD) begin
         s = int'(b.slot);
         if (s < pps_pkg::MAX_TASKS) begin
            // count a slot once; retract its old done mark on reload
            if (!valid_tab[s]) begin
               valid_tab[s] = 1'b1;
               loaded_n++;
            end else if (done_tab[s]) begin
               done_n--;
            end
            arr_tab[s]   = b.arrival;
            burst_tab[s] = b.burst;
            rem_tab[s]   = b.burst;
            prio_tab[s]  = b.prio;
            done_tab[s]  = (b.burst == '0);
            if (done_tab[s]) done_n++;
         end
         return;
      end
      // pick the most urgent arrived task, lowest slot on a tie
      found   = 1'b0;
      best    = 0;
      best_pr = '0;
      for (int i = 0; i < pps_pkg::MAX_TASKS; i++) begin
         if (valid_tab[i] && !done_tab[i] && rem_tab[i] != '0 && arr_tab[i] <= now_t) begin
            if (!found || prio_tab[i] < best_pr) begin
               found   = 1'b1;
               best    = i;
               best_pr = prio_tab[i];
            end
         end
      end
      nxt  = (now_t != pps_pkg::TIME_MAX) ? now_t + 1'b1 : now_t;
      code = found ? pps_pkg::CODE_BITS'(best) : pps_pkg::IDLE_CODE;
      r              = '0;
      r.is_idle      = !found;
      r.running_slot = found ? pps_pkg::SLOT_BITS'(best) : '0;
      r.switched     = (code != last_code);
      r.tick_start   = now_t;
      // serve one tick; report times on completion
      if (found) begin
         rem_tab[best] = rem_tab[best] - 1'b1;
         if (rem_tab[best] == '0) begin
            done_tab[best]    = 1'b1;
            done_n++;
            tat               = nxt - arr_tab[best];
            r.finished        = 1'b1;
            r.completion_time = nxt;
            r.turnaround      = tat;
            r.waiting         = (tat >= burst_tab[best]) ? tat - burst_tab[best] : '0;
         end
      end
      now_t      = nxt;
      r.all_done = (done_n == loaded_n);
      last_code  = code;
      expected_reports = {expected_reports, r};
   endfunction

   task automatic push_load(input int s, input int arr, input int burst, input int prio);
      task_beat_type b;
      b.cmd     = pps_pkg::CMD_LOAD;
      b.slot    = pps_pkg::SLOT_BITS'(s);
      b.arrival = pps_pkg::FIELD_BITS'(arr);
      b.burst   = pps_pkg::FIELD_BITS'(burst);
      b.prio    = pps_pkg::PRIO_BITS'(prio);
      pending_beats = {pending_beats, b};
   endtask

   task automatic push_ticks(input int n);
      task_beat_type b;
      b      = '0;
      b.cmd  = pps_pkg::CMD_TICK;
      for (int i = 0; i < n; i++) begin
         b.slot    = pps_pkg::SLOT_BITS'($urandom);
         b.arrival = pps_pkg::FIELD_BITS'($urandom);
         b.burst   = pps_pkg::FIELD_BITS'($urandom);
         b.prio    = pps_pkg::PRIO_BITS'($urandom);
         pending_beats = {pending_beats, b};
      end
      queued_ticks += n;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   // Driver: present the next beat once the previous one is taken.
   always @(posedge clock) begin
      logic nxt_start;
      nxt_start = start;
      if (!reset) begin
         if (start && !busy) begin
            schedule_beat(cur_beat);
            nxt_start = 1'b0;
         end
         if (!nxt_start) begin
            if (gap_left == 0 && pending_beats.size() > quiet_beats &&
                $urandom_range(0, 99) < idle_pct)
               gap_left = $urandom_range(1, 8);
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() != 0) begin
               cur_beat          = pending_beats.pop_front();
               req_cmd           <= cur_beat.cmd;
               req_slot          <= cur_beat.slot;
               req_arrival_time  <= cur_beat.arrival;
               req_burst_length  <= cur_beat.burst;
               req_task_priority <= cur_beat.prio;
               nxt_start         = 1'b1;
               beats_sent++;
               // vary idling density, with stretches of none
               if (beats_sent % 40 == 0) begin
                  case ($urandom_range(0, 2))
                     0: idle_pct = 0;
                     1: idle_pct = 12;
                     default: idle_pct = 40;
                  endcase
               end
            end
         end
      end
      start <= nxt_start;
   end

   // Monitor: match each report beat against the oldest prediction.
   always @(posedge clock) begin
      tick_report_type want;
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            $error("report beat with no tick pending (slot %0d, start %0d)",
                   rsp_running_slot, rsp_tick_start);
            errors++;
         end else begin
            want = expected_reports.pop_front();
            check_field("is_idle", want.is_idle, rsp_is_idle);
            check_field("running_slot", want.running_slot, rsp_running_slot);
            check_field("switched", want.switched, rsp_switched);
            check_field("tick_start", want.tick_start, rsp_tick_start);
            check_field("finished", want.finished, rsp_finished);
            check_field("completion_time", want.completion_time, rsp_completion_time);
            check_field("turnaround", want.turnaround, rsp_turnaround);
            check_field("waiting", want.waiting, rsp_waiting);
            check_field("all_done", want.all_done, rsp_all_done);
         end
      end
   end

   initial begin
      int n;
      int total;
      int burst;
      int arr;
      int rand_goal;
      int quiet_start;
      int cycles;
      int cycle_limit;

      // empty table: idle ticks, first one switches, all_done with nothing loaded
      push_ticks(2);
      // zero burst is done at load
      push_load(0, 0, 0, 0);
      push_ticks(1);
      // extreme fields, far in the future
      push_load(15, 16'hFFFF, 16'hFFFF, 8'hFF);
      push_load(1, 0, 2, 5);
      // equal priorities: lower slot wins
      push_load(3, 0, 2, 9);
      push_load(4, 0, 2, 9);
      push_ticks(1);
      // late urgent arrival preempts
      push_load(2, 5, 1, 1);
      push_ticks(3);
      // reload a done slot and an unfinished one
      push_load(0, 0, 3, 200);
      push_load(3, 0, 1, 9);
      // reload an unfinished slot with zero burst
      push_load(15, 0, 0, 128);
      push_ticks(8);

      // random task sets, mostly well formed
      rand_goal = pending_beats.size() + RAND_BEATS;
      while (pending_beats.size() < rand_goal) begin
         if ($urandom_range(0, 3) != 0) begin
            n     = $urandom_range(1, 5);
            total = 0;
            for (int k = 0; k < n; k++) begin
               arr   = queued_ticks + $urandom_range(0, 12);
               if (arr > 16'hFFFF) arr = 16'hFFFF;
               burst = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
               push_load($urandom_range(0, 15), arr, burst,
                         $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
               total += burst;
               if ($urandom_range(0, 9) < 3) begin
                  n = $urandom_range(1, 3);
                  push_ticks(n);
                  total -= n;
                  n = k + 2 + $urandom_range(0, 1) - 1;
               end
            end
            if (total < 0) total = 0;
            push_ticks(total + $urandom_range(0, 6));
         end else begin
            case ($urandom_range(0, 2))
               0: push_load($urandom_range(0, 15), $urandom, $urandom, $urandom);
               1: push_ticks($urandom_range(1, 4));
               default: push_load($urandom_range(0, 15), $urandom_range(0, queued_ticks),
                                  $urandom_range(0, 3), $urandom_range(0, 255));
            endcase
         end
      end

      // closing stretch with no idling: refill the table and run it dry
      quiet_start = pending_beats.size();
      for (int s = 0; s < pps_pkg::MAX_TASKS; s++)
         push_load(s, queued_ticks + $urandom_range(0, 6), $urandom_range(0, 2),
                   $urandom_range(0, 255));
      push_ticks(40);
      quiet_beats = pending_beats.size() - quiet_start;
      cycle_limit = 4 * pending_beats.size() * (LATENCY + 8 + 4) + 20000;

      // hold reset, then release
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait for every beat and report, bounded by the cycle limit
      cycles = 0;
      while ((pending_beats.size() != 0 || start || expected_reports.size() != 0) &&
             cycles < cycle_limit) begin
         @(posedge clock);
         cycles++;
      end
      if (cycles >= cycle_limit) begin
         $error("timeout after %0d cycles, %0d reports outstanding",
                cycles, expected_reports.size());
         errors++;
      end else begin
         repeat (2 * LATENCY) @(posedge clock);
         if (expected_reports.size() != 0) begin
            $error("%0d tick reports never arrived", expected_reports.size());
            errors++;
         end
      end
      if (errors == 0)
         $display("** preemptive_priority_scheduler: PASSED **");
      else
         $display("** preemptive_priority_scheduler: FAILED **");
      $finish;
   end

endmodule
